// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int ENTRIES_W = 6;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_BACK  = 2'd0,
		KIND_PUSH_FRONT = 2'd1,
		KIND_POP_BACK   = 2'd2,
		KIND_SEARCH     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		status_t          status;
		logic             found;
		logic [CNT_W-1:0] count;
	} result_t;

endpackage

// ===== rtl/bdq_store.sv =====
module bdq_store (
	input  logic                       clk,
	input  bdq_pkg::mem_req_t          req,
	output logic [bdq_pkg::BYTE_W-1:0] rd_data
);
	import bdq_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.addr];
		end
	end

endmodule

// ===== rtl/bdq_ctrl.sv =====
module bdq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bdq_pkg::KIND_W-1:0] kind,
	input  logic [bdq_pkg::BYTE_W-1:0] value,
	output bdq_pkg::mem_req_t          mem_req,
	input  logic [bdq_pkg::BYTE_W-1:0] rd_data,
	input  logic                       out_free,
	output logic                       res_valid,
	output bdq_pkg::result_t           res
);
	import bdq_pkg::*;

	state_t            state_q, state_n;
	kind_t             kind_q, kind_n;
	logic [BYTE_W-1:0] value_q, value_n;
	logic [IDX_W-1:0]  head_q, head_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [CNT_W-1:0]  off_q, off_n;
	logic              cmp_vld_q, cmp_vld_n;
	status_t           status_q, status_n;
	logic              found_q, found_n;

	// Shared slot unit: head plus an offset, wrapped once into the store.
	logic [CNT_W-1:0] operand;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] wrapped;
	logic [IDX_W-1:0] slot;
	logic             is_full;
	logic             is_empty_now;
	logic             match;

	always_comb begin
		operand = count_q;
		case (state_q)
			S_EXEC: begin
				if (kind_q == KIND_PUSH_FRONT) begin
					operand = CNT_W'(DEPTH - 1);
				end
			end
			S_SCAN: begin
				operand = off_q;
			end
			default: begin
				operand = count_q;
			end
		endcase
		sum = SUM_W'(head_q) + SUM_W'(operand);
		wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
		slot = wrapped[IDX_W-1:0];
	end

	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_empty_now = (count_q == '0);
	assign match = cmp_vld_q && (rd_data == value_q);

	always_comb begin
		state_n = state_q;
		kind_n = kind_q;
		value_n = value_q;
		head_n = head_q;
		count_n = count_q;
		off_n = off_q;
		cmp_vld_n = 1'b0;
		status_n = status_q;
		found_n = found_q;
		in_stall = 1'b1;
		res_valid = 1'b0;
		mem_req.we = 1'b0;
		mem_req.re = 1'b0;
		mem_req.addr = slot;
		mem_req.wdata = value_q;

		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					kind_n = kind_t'(kind);
					value_n = value;
					status_n = ST_DONE;
					found_n = 1'b0;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				state_n = S_DONE;
				case (kind_q)
					KIND_PUSH_BACK: begin
						if (is_full) begin
							status_n = ST_FULL;
						end else begin
							mem_req.we = 1'b1;
							count_n = count_q + 1'b1;
						end
					end
					KIND_PUSH_FRONT: begin
						if (is_full) begin
							status_n = ST_FULL;
						end else begin
							mem_req.we = 1'b1;
							head_n = slot;
							count_n = count_q + 1'b1;
						end
					end
					KIND_POP_BACK: begin
						if (is_empty_now) begin
							status_n = ST_EMPTY;
						end else begin
							count_n = count_q - 1'b1;
						end
					end
					default: begin
						if (is_empty_now) begin
							status_n = ST_EMPTY;
						end else begin
							off_n = '0;
							state_n = S_SCAN;
						end
					end
				endcase
			end
			S_SCAN: begin
				// The read issued last cycle is compared while the next one goes out.
				if (match) begin
					found_n = 1'b1;
					state_n = S_DONE;
				end else if (off_q < count_q) begin
					mem_req.re = 1'b1;
					off_n = off_q + 1'b1;
					cmp_vld_n = 1'b1;
				end else begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign res.status = status_q;
	assign res.found = found_q;
	assign res.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			off_q <= '0;
			cmp_vld_q <= 1'b0;
			status_q <= ST_DONE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_n;
			head_q <= head_n;
			count_q <= count_n;
			off_q <= off_n;
			cmp_vld_q <= cmp_vld_n;
			status_q <= status_n;
			found_q <= found_n;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_n;
		value_q <= value_n;
	end

endmodule

// ===== rtl/byte_deque_with_search_top.sv =====
// Bounded double-ended queue of bytes with a front-to-back search.
// Input channel (in_valid, in_stall, kind, value): one operation per transfer,
// push back, push front, pop back or search for value.
// Output channel (out_valid, out_stall, status, found, is_empty, entries): one
// result per operation, giving status, search hit, empty flag and entry count
// after the operation.
// A push or pop passes from the input transfer through the execute state to
// the done state, where its result is loaded into the output register.
// A search reads one stored entry per cycle through a single memory read port
// and one byte comparator in a scan state between execute and done, and it
// stops at the first hit. The next input transfer is taken in the idle state
// that follows done.
// The block takes one operation at a time: in_stall is high from the transfer
// until the result has been loaded into the output register.
// A result waiting in the output register does not block the next transfer,
// but that next result is held back until the waiting one has been taken.
// While out_stall is high, a valid result holds: out_valid and the result fields stay.
// Reset (arst_n low) empties the queue at once; the byte store is not cleared,
// since only occupied entries are ever read.
module byte_deque_with_search_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic       found,
	output logic       is_empty,
	output logic [5:0] entries
);
	import bdq_pkg::*;

	mem_req_t          mem_req;
	logic [BYTE_W-1:0] rd_data;
	logic              out_free;
	logic              res_valid;
	result_t           res;
	logic              out_valid_q;
	result_t           out_res_q;

	assign out_free = !out_valid_q || !out_stall;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	bdq_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_res_q.status;
	assign found = out_res_q.found;
	assign is_empty = (out_res_q.count == '0);
	assign entries = ENTRIES_W'(out_res_q.count);

endmodule
